[rtl/assert_macros.svh]
// Assertion macros for the RTL; tpg_datapath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge and held off while reset is high.
`define TPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/tpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_pkg
// Types and constants shared by the triangle particle generator modules.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam int COORD_W       = 32;
  localparam int VOL_W         = 32;
  localparam int NUM_W         = 41;
  localparam int DEN_W         = 7;
  localparam int DIV_CNT_W     = 6;
  localparam int CNT_W         = 7;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 8;
  localparam int MAX_DIVISIONS = 8;

  localparam logic [1:0] MODE_CENTROID = 2'd0;
  localparam logic [1:0] MODE_GAUSS    = 2'd1;
  localparam logic [1:0] MODE_SPLIT    = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PLACEMENT_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISION_COUNT = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOL_START,
    ST_VOL_WAIT,
    ST_PT_PREP,
    ST_PT_START,
    ST_PT_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic vol_start;
    logic vol_take;
    logic pt_prep;
    logic pt_start;
    logic pt_take;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_last;
  } dp_status_t;

endpackage

[rtl/tpg_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_divider
// Restoring divider, one quotient bit per cycle, floor rounding of a signed
// numerator by a small positive divisor. Gives the low 32 quotient bits.
// ----------------------------------------------------------------------------
module tpg_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [tpg_pkg::NUM_W-1:0] num,
  input  logic [tpg_pkg::DEN_W-1:0]       den,
  output logic                            busy,
  output logic                            done,
  output logic [tpg_pkg::COORD_W-1:0]     quot
);

  logic [tpg_pkg::NUM_W-1:0]     mag;
  logic [tpg_pkg::DEN_W-1:0]     rem;
  logic [tpg_pkg::DEN_W-1:0]     divisor;
  logic                          neg;
  logic [tpg_pkg::DIV_CNT_W-1:0] count;
  logic [tpg_pkg::DEN_W:0]       trial;
  logic [tpg_pkg::DEN_W:0]       diff;
  logic                          fits;
  logic [tpg_pkg::COORD_W-1:0]   q_low;

  assign trial = {rem, mag[tpg_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= tpg_pkg::DIV_CNT_W'(tpg_pkg::NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == tpg_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag     <= num[tpg_pkg::NUM_W-1] ? -num : num;
      neg     <= num[tpg_pkg::NUM_W-1];
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      rem <= fits ? diff[tpg_pkg::DEN_W-1:0] : trial[tpg_pkg::DEN_W-1:0];
      mag <= {mag[tpg_pkg::NUM_W-2:0], fits};
    end
  end

  // A negative numerator with a remainder rounds one further down: -q-1 = ~q.
  assign q_low = mag[tpg_pkg::COORD_W-1:0];
  always_comb begin
    if (!neg) begin
      quot = q_low;
    end else if (rem != '0) begin
      quot = ~q_low;
    end else begin
      quot = -q_low;
    end
  end

endmodule

[rtl/tpg_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_datapath
// Configuration registers, triangle latch, point sequencing, numerator
// formation, two dividers (the x divider also divides the volume) and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tpg_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tpg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tpg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [7*tpg_pkg::COORD_W-1:0]       in_data,
  input  tpg_pkg::dp_cmd_t                    cmd,
  output tpg_pkg::dp_status_t                 status,
  output logic [3*tpg_pkg::COORD_W-1:0]       out_data,
  output logic                                out_last
);

  localparam int NW = tpg_pkg::NUM_W;
  localparam int CW = tpg_pkg::COORD_W;

  logic [1:0] placement_mode;
  logic [3:0] division_count;
  logic [1:0] mode;
  logic [3:0] n;
  logic [3:0] n_sat;
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  logic [tpg_pkg::VOL_W-1:0] vol;
  logic [tpg_pkg::VOL_W-1:0] vol_share;
  logic [tpg_pkg::CNT_W-1:0] cnt;
  logic [2:0] row;
  logic [2:0] col;
  logic       second;
  logic signed [NW-1:0] x_num;
  logic signed [NW-1:0] y_num;
  logic [CW-1:0] px, py, pvol;
  logic          plast;

  logic [tpg_pkg::CNT_W-1:0] total;
  logic                      last;
  logic [tpg_pkg::DEN_W-1:0] vol_den;
  logic [tpg_pkg::DEN_W-1:0] coord_den;
  logic [tpg_pkg::DEN_W-1:0] nn;
  logic signed [NW-1:0] sum_x, sum_y, sel_x, sel_y, dx21, dy21, dx32, dy32;
  logic [4:0] rw, cw;
  logic signed [NW-1:0] x_num_next, y_num_next;
  logic          xd_start;
  logic signed [NW-1:0] xd_num;
  logic [tpg_pkg::DEN_W-1:0] xd_den;
  logic          x_busy, x_done, y_busy, y_done;
  logic [CW-1:0] x_quot, y_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      placement_mode <= tpg_pkg::MODE_CENTROID;
      division_count <= 4'd1;
    end else if (cfg_write) begin
      if (cfg_index == tpg_pkg::REG_PLACEMENT_MODE) begin
        placement_mode <= cfg_data[1:0];
      end else if (cfg_index == tpg_pkg::REG_DIVISION_COUNT) begin
        division_count <= cfg_data[3:0];
      end
    end
  end

  always_comb begin
    if (division_count == 4'd0) begin
      n_sat = 4'd1;
    end else if (division_count > 4'(tpg_pkg::MAX_DIVISIONS)) begin
      n_sat = 4'(tpg_pkg::MAX_DIVISIONS);
    end else begin
      n_sat = division_count;
    end
  end

  assign nn = tpg_pkg::DEN_W'(n) * tpg_pkg::DEN_W'(n);

  always_comb begin
    case (mode)
      tpg_pkg::MODE_GAUSS: begin
        total     = tpg_pkg::CNT_W'(3);
        vol_den   = tpg_pkg::DEN_W'(3);
        coord_den = tpg_pkg::DEN_W'(6);
      end
      tpg_pkg::MODE_SPLIT: begin
        total     = nn;
        vol_den   = nn;
        coord_den = tpg_pkg::DEN_W'(3) * tpg_pkg::DEN_W'(n);
      end
      default: begin
        total     = tpg_pkg::CNT_W'(1);
        vol_den   = tpg_pkg::DEN_W'(1);
        coord_den = tpg_pkg::DEN_W'(3);
      end
    endcase
  end

  assign last = (cnt + 1'b1) == total;

  // Numerators for the current point.
  assign sum_x = NW'(ax) + NW'(bx) + NW'(cx);
  assign sum_y = NW'(ay) + NW'(by) + NW'(cy);
  always_comb begin
    case (cnt[1:0])
      2'd0:    begin sel_x = NW'(ax); sel_y = NW'(ay); end
      2'd1:    begin sel_x = NW'(bx); sel_y = NW'(by); end
      default: begin sel_x = NW'(cx); sel_y = NW'(cy); end
    endcase
  end
  assign dx21 = NW'(bx) - NW'(ax);
  assign dy21 = NW'(by) - NW'(ay);
  assign dx32 = NW'(cx) - NW'(bx);
  assign dy32 = NW'(cy) - NW'(by);
  assign rw = 5'(3) * 5'(row) + (second ? 5'd1 : 5'd2);
  assign cw = 5'(3) * 5'(col) + (second ? 5'd2 : 5'd1);

  always_comb begin
    case (mode)
      tpg_pkg::MODE_GAUSS: begin
        x_num_next = sum_x + 3 * sel_x;
        y_num_next = sum_y + 3 * sel_y;
      end
      tpg_pkg::MODE_SPLIT: begin
        x_num_next = NW'(signed'({1'b0, rw})) * dx21 + NW'(signed'({1'b0, cw})) * dx32;
        y_num_next = NW'(signed'({1'b0, rw})) * dy21 + NW'(signed'({1'b0, cw})) * dy32;
      end
      default: begin
        x_num_next = sum_x;
        y_num_next = sum_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax   <= in_data[0*CW +: CW];
      ay   <= in_data[1*CW +: CW];
      bx   <= in_data[2*CW +: CW];
      by   <= in_data[3*CW +: CW];
      cx   <= in_data[4*CW +: CW];
      cy   <= in_data[5*CW +: CW];
      vol  <= in_data[6*CW +: CW];
      mode <= (placement_mode == tpg_pkg::MODE_UNUSED) ? tpg_pkg::MODE_CENTROID
                                                       : placement_mode;
      n    <= n_sat;
    end
    if (cmd.vol_take) begin
      vol_share <= x_quot;
    end
    if (cmd.pt_prep) begin
      x_num <= x_num_next;
      y_num <= y_num_next;
    end
    if (cmd.pt_take) begin
      px    <= (mode == tpg_pkg::MODE_SPLIT) ? ax + x_quot : x_quot;
      py    <= (mode == tpg_pkg::MODE_SPLIT) ? ay + y_quot : y_quot;
      pvol  <= vol_share;
      plast <= last;
    end
  end

  // Point order in subdivision: a pair of points per column below the
  // diagonal, then the single diagonal point closes the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      row    <= '0;
      col    <= '0;
      second <= 1'b0;
    end else if (cmd.load) begin
      cnt    <= '0;
      row    <= '0;
      col    <= '0;
      second <= 1'b0;
    end else if (cmd.pt_take) begin
      cnt <= cnt + 1'b1;
      if (second) begin
        second <= 1'b0;
        col    <= col + 1'b1;
      end else if (col < row) begin
        second <= 1'b1;
      end else begin
        row <= row + 1'b1;
        col <= '0;
      end
    end
  end

  assign xd_start = cmd.vol_start | cmd.pt_start;
  assign xd_num   = cmd.vol_start ? NW'(vol) : x_num;
  assign xd_den   = cmd.vol_start ? vol_den : coord_den;

  tpg_divider u_x_div (
    .clk   (clk),
    .rst   (rst),
    .start (xd_start),
    .num   (xd_num),
    .den   (xd_den),
    .busy  (x_busy),
    .done  (x_done),
    .quot  (x_quot)
  );

  tpg_divider u_y_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.pt_start),
    .num   (y_num),
    .den   (coord_den),
    .busy  (y_busy),
    .done  (y_done),
    .quot  (y_quot)
  );

  assign status.div_done = x_done;
  assign status.out_last = plast;
  assign out_data        = {pvol, py, px};
  assign out_last        = plast;

  `TPG_ASSERT(a_start_idle, xd_start |-> !x_busy && !y_busy, "divider started while busy")
  `TPG_ASSERT(a_pt_lockstep, cmd.pt_start |=> x_busy == y_busy, "dividers out of step")
  `TPG_ASSERT(a_take_fresh, (cmd.pt_take || cmd.vol_take) |-> x_done, "quotient taken early")
  `TPG_ASSERT(a_y_fresh, cmd.pt_take |-> y_done, "y quotient taken early")

endmodule

[rtl/tpg_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_controller
// Sequences one triangle: volume share, then one divide per particle, and
// holds each particle on the output until its beat is taken.
// ----------------------------------------------------------------------------
module tpg_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tpg_pkg::dp_status_t status,
  output tpg_pkg::dp_cmd_t    cmd
);

  tpg_pkg::state_t state;
  tpg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tpg_pkg::ST_IDLE:      if (in_valid) state_next = tpg_pkg::ST_VOL_START;
      tpg_pkg::ST_VOL_START: state_next = tpg_pkg::ST_VOL_WAIT;
      tpg_pkg::ST_VOL_WAIT:  if (status.div_done) state_next = tpg_pkg::ST_PT_PREP;
      tpg_pkg::ST_PT_PREP:   state_next = tpg_pkg::ST_PT_START;
      tpg_pkg::ST_PT_START:  state_next = tpg_pkg::ST_PT_WAIT;
      tpg_pkg::ST_PT_WAIT:   if (status.div_done) state_next = tpg_pkg::ST_EMIT;
      tpg_pkg::ST_EMIT: begin
        if (out_ready) begin
          state_next = status.out_last ? tpg_pkg::ST_IDLE : tpg_pkg::ST_PT_PREP;
        end
      end
      default:               state_next = tpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      tpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tpg_pkg::ST_VOL_START: cmd.vol_start = 1'b1;
      tpg_pkg::ST_VOL_WAIT:  cmd.vol_take  = status.div_done;
      tpg_pkg::ST_PT_PREP:   cmd.pt_prep   = 1'b1;
      tpg_pkg::ST_PT_START:  cmd.pt_start  = 1'b1;
      tpg_pkg::ST_PT_WAIT:   cmd.pt_take   = status.div_done;
      tpg_pkg::ST_EMIT:      out_valid     = 1'b1;
      default:               cmd           = '0;
    endcase
  end

endmodule

[rtl/triangle_particle_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_particle_generator
// Turns one triangle into centroid, Gauss-point or subdivision particles.
// ----------------------------------------------------------------------------
// One triangle is taken at a time. Its volume share is found first, then
// each particle is divided out and held on the output until it is taken,
// for P particles per triangle (P = 1, 3 or n*n up to 64). The dividers
// are 41-bit restoring dividers, which produce one quotient bit per cycle;
// x and y are divided side by side. Configuration is written through the
// cfg channel, which is always ready.
module triangle_particle_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
  // triangle_volume (32 bits each, from the lowest bit up)
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // point_x, point_y, point_volume (32 bits each, from the lowest bit up)
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [tpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpg_pkg::CFG_DATA_W-1:0] cfg_data
);

  tpg_pkg::dp_cmd_t    cmd;
  tpg_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tpg_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tpg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
